// File: hdl/url_form_field_extract_defines.svh
// assertion macros shared by the block
`ifndef URL_FORM_FIELD_EXTRACT_DEFINES_SVH
`define URL_FORM_FIELD_EXTRACT_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FFX_ASSERT_IMP(lbl, ante, cons, msg)
`define FFX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/url_ffx_pkg.sv
package url_ffx_pkg;

  localparam int MAX_NAME_BYTES   = 16;
  localparam int MAX_CAPACITY_DEF = 256;
  localparam logic [8:0] CAP_RESET = 9'd64;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_SKIP,
    PH_VALUE,
    PH_HEX1,
    PH_HEX2,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD       = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_NAME_LOW  = 2'd0,
    REG_NAME_HIGH = 2'd1,
    REG_NAME_LEN  = 2'd2,
    REG_CAPACITY  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [127:0] name;
    logic [4:0]   key_len;
    logic [8:0]   capacity;
  } cfg_t;

  // results made by one body item: an optional value byte, then an optional status
  typedef struct packed {
    logic    has_val;
    logic [7:0] val_byte;
    logic    has_stat;
    status_t status;
    logic [7:0] vlen;
  } rec_t;

  // bit 4 set when the character is a hex digit, low nibble its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: hdl/url_ffx_decode.sv
module url_ffx_decode
  import url_ffx_pkg::*;
#(
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [7:0] in_byte,
  input  logic       in_has,
  input  logic       in_last,
  input  cfg_t       cfg,
  output logic       rec_v,
  output rec_t       rec
);

  localparam int WC_W   = $clog2(MAX_CAPACITY);
  localparam int CAP_WB = $clog2(MAX_CAPACITY + 1);
  localparam int CAP_W  = (CAP_WB > 9) ? CAP_WB : 9;

  phase_t          phase_r, phase_nxt, ph_b;
  logic [4:0]      kp_r, kp_nxt;
  logic            km_r, km_nxt;
  logic [3:0]      hn_r, hn_nxt;
  logic [WC_W-1:0] wc_r, wc_nxt, wc_b;
  status_t         oc_r, oc_nxt, oc_b;

  logic [CAP_W-1:0] cap_ext, cap_now;
  logic [4:0]       hex;
  logic [7:0]       name_chr;
  logic             room, val_ok;
  status_t          stat;

  assign cap_ext = CAP_W'(cfg.capacity);
  assign cap_now = (cap_ext > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : cap_ext;
  assign room    = ((CAP_W + 1)'(wc_r) + (CAP_W + 1)'(1)) < (CAP_W + 1)'(cap_now);
  assign hex     = hex_decode(in_byte);
  assign name_chr = cfg.name[{kp_r[3:0], 3'b000} +: 8];

  // byte step, then the end-of-body clear
  always_comb begin
    ph_b   = phase_r;
    kp_nxt = kp_r;
    km_nxt = km_r;
    hn_nxt = hn_r;
    wc_b   = wc_r;
    oc_b   = oc_r;
    if (in_has) begin
      case (phase_r)
        PH_KEY: begin
          if (in_byte == CH_AMP) begin
            kp_nxt = 5'd0;
            km_nxt = 1'b0;
          end else if (in_byte == CH_EQ) begin
            if (!km_r && kp_r == cfg.key_len && cfg.key_len <= 5'(MAX_NAME_BYTES)) begin
              ph_b = PH_VALUE;
            end else begin
              ph_b = PH_SKIP;
            end
          end else if (km_r || kp_r >= cfg.key_len || kp_r >= 5'(MAX_NAME_BYTES) ||
                       name_chr != in_byte) begin
            km_nxt = 1'b1;
          end else begin
            kp_nxt = kp_r + 5'd1;
          end
        end
        PH_SKIP: begin
          if (in_byte == CH_AMP) begin
            ph_b   = PH_KEY;
            kp_nxt = 5'd0;
            km_nxt = 1'b0;
          end
        end
        PH_VALUE: begin
          if (in_byte == CH_AMP) begin
            oc_b = ST_FOUND;
            ph_b = PH_DONE;
          end else if (in_byte == CH_PCT) begin
            ph_b = PH_HEX1;
          end else if (room) begin
            wc_b = wc_r + WC_W'(1);
          end else begin
            oc_b = ST_BAD;
            ph_b = PH_DONE;
          end
        end
        PH_HEX1: begin
          if (!hex[4]) begin
            oc_b = ST_BAD;
            ph_b = PH_DONE;
          end else begin
            hn_nxt = hex[3:0];
            ph_b   = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (hex[4] && room) begin
            wc_b = wc_r + WC_W'(1);
            ph_b = PH_VALUE;
          end else begin
            oc_b = ST_BAD;
            ph_b = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    phase_nxt = ph_b;
    wc_nxt    = wc_b;
    oc_nxt    = oc_b;
    if (in_last) begin
      phase_nxt = PH_KEY;
      kp_nxt    = 5'd0;
      km_nxt    = 1'b0;
      hn_nxt    = 4'd0;
      wc_nxt    = '0;
      oc_nxt    = ST_NOT_FOUND;
    end
  end

  // results of this item
  always_comb begin
    val_ok = in_has && room &&
             ((phase_r == PH_VALUE && in_byte != CH_AMP && in_byte != CH_PCT) ||
              (phase_r == PH_HEX2 && hex[4]));
    case (ph_b)
      PH_DONE:           stat = oc_b;
      PH_VALUE:          stat = ST_FOUND;
      PH_HEX1, PH_HEX2:  stat = ST_BAD;
      default:           stat = ST_NOT_FOUND;
    endcase
    if (cap_now == '0) begin
      stat = ST_BAD;
    end
    rec.has_val  = val_ok;
    rec.val_byte = (phase_r == PH_HEX2) ? {hn_r, hex[3:0]} :
                   ((in_byte == CH_PLUS) ? CH_SPACE : in_byte);
    rec.has_stat = in_last;
    rec.status   = stat;
    rec.vlen     = (stat == ST_FOUND) ? 8'(wc_b) : 8'd0;
    rec_v        = in_accept && (val_ok || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      kp_r    <= 5'd0;
      km_r    <= 1'b0;
      hn_r    <= 4'd0;
      wc_r    <= '0;
      oc_r    <= ST_NOT_FOUND;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      kp_r    <= kp_nxt;
      km_r    <= km_nxt;
      hn_r    <= hn_nxt;
      wc_r    <= wc_nxt;
      oc_r    <= oc_nxt;
    end
  end

endmodule

// File: hdl/url_ffx_outq.sv
module url_ffx_outq
  import url_ffx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop_ready,
  output logic head_valid,
  output rec_t head,
  output logic full
);

  // two record slots; the head sends its value byte first, then its status
  logic v0_r, v0_nxt, v1_r, v1_nxt;
  rec_t s0_r, s0_nxt, s1_r, s1_nxt;
  logic take, head_done;

  assign head_valid = v0_r;
  assign head       = s0_r;
  assign full       = v1_r;
  assign take       = v0_r && pop_ready;
  assign head_done  = take && (!s0_r.has_val || !s0_r.has_stat);

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (head_done) begin
      v0_nxt = v1_r;
      s0_nxt = s1_r;
      v1_nxt = 1'b0;
      if (push && !v1_r) begin
        v0_nxt = 1'b1;
        s0_nxt = push_rec;
      end
    end else begin
      if (take) begin
        s0_nxt.has_val = 1'b0;
      end
      if (push) begin
        if (v0_r) begin
          v1_nxt = 1'b1;
          s1_nxt = push_rec;
        end else begin
          v0_nxt = 1'b1;
          s0_nxt = push_rec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

endmodule

// File: hdl/url_form_field_extract.sv
// URL-encoded form field extractor.
// in_*: one body byte per request; in_tuser flags a valid byte (0 for a byteless
// request, such as the end marker of an empty body), in_tlast marks the final request of the body.
// out_*: result stream; out_tuser 0 is a decoded value byte, 1 the status that
// closes the body (also flagged by out_tlast). A bad status means every value
// byte sent for this body is to be thrown away.
// cfg_*: register writes, always ready; write only while the block is idle.
// Latency: with the queue empty, results of a request are presented the cycle
// after it is taken.
// Throughput: one request per cycle while out_tready is high and each makes at
// most one result; a request that makes both a value byte and a status holds
// the result port for both transfers, so the two-slot result queue sets the rate.
// Reset clears the parse state and the queue and loads the register defaults
// (capacity 64, empty name). When out_tready is low the queue holds its
// results; in_tready drops once both slots are occupied.
`include "url_form_field_extract_defines.svh"

module url_form_field_extract
  import url_ffx_pkg::*;
#(
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // body_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // body_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value_byte, status, value_length, zero fill
  output logic        out_tuser,  // item_kind
  output logic        out_tlast,  // result_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] name_lo_r, name_hi_r;
  logic [4:0]  key_len_r;
  logic [8:0]  cap_r;
  cfg_t        cfg;
  logic        in_accept, rec_v, q_full, head_valid;
  rec_t        rec, head;

  assign cfg_ready = 1'b1;
  assign cfg.name     = {name_hi_r, name_lo_r};
  assign cfg.key_len  = key_len_r;
  assign cfg.capacity = cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_lo_r  <= 64'd0;
      name_hi_r  <= 64'd0;
      key_len_r  <= 5'd0;
      cap_r      <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NAME_LOW:  name_lo_r  <= cfg_data;
        REG_NAME_HIGH: name_hi_r  <= cfg_data;
        REG_NAME_LEN:  key_len_r  <= cfg_data[4:0];
        REG_CAPACITY:  cap_r      <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  url_ffx_decode #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_byte  (in_tdata),
    .in_has   (in_tuser),
    .in_last  (in_tlast),
    .cfg      (cfg),
    .rec_v    (rec_v),
    .rec      (rec)
  );

  url_ffx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_v),
    .push_rec  (rec),
    .pop_ready (out_tready),
    .head_valid(head_valid),
    .head      (head),
    .full      (q_full)
  );

  assign out_tvalid = head_valid;
  assign out_tuser  = !head.has_val;
  assign out_tlast  = !head.has_val;
  assign out_tdata  = head.has_val ? {6'd0, 8'd0, ST_FOUND, head.val_byte}
                                   : {6'd0, head.vlen, head.status, 8'd0};

  `FFX_ASSERT_IMP(a_full_has_head, !in_tready, out_tvalid, "queue full without a head result")
  `FFX_ASSERT_NEXT(a_last_gives_status, in_tvalid && in_tready && in_tlast, out_tvalid, "no status")
  `FFX_ASSERT_IMP(a_status_code, out_tvalid && out_tuser, out_tdata[9:8] != 2'b11, "status code")

endmodule

// File: test/url_form_field_extract_test.sv
`timescale 1ns / 100ps

module url_form_field_extract_test;
  import url_ffx_pkg::*;

  localparam int CAP_CEILING = MAX_CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 360;
  localparam int PHASE_ITEMS = 40;
  localparam int CALM_ITEMS = 120;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] vbyte;
    status_t    st;
    logic [7:0] vlen;
    logic       last;
  } form_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_NAME_LOW;
  logic [63:0] cfg_data = 64'h0;

  // results the block should produce, oldest first
  form_result_t pending_results[$];
  logic [7:0]   body_buf[$];

  int  errors = 0;
  int  bytes_taken = 0;
  int  quiet_cycles = 0;
  bit  idle_in = 1'b1;
  bit  idle_out = 1'b1;
  logic hold_request = 1'b0;

  // shadow of the block's registers and parse state
  logic [127:0] name_cfg = 128'h0;
  logic [4:0]   key_len_cfg = 5'd0;
  logic [8:0]   capacity_cfg = CAP_RESET;
  phase_t       parse_phase;
  logic [4:0]   key_pos;
  logic         key_miss;
  logic [3:0]   hi_nib;
  int           value_count;
  status_t      body_status;

  url_form_field_extract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void clear_parse_state();
    parse_phase = PH_KEY;
    key_pos = 5'd0;
    key_miss = 1'b0;
    hi_nib = 4'd0;
    value_count = 0;
    body_status = ST_NOT_FOUND;
  endfunction

  function automatic int cap_limit();
    return (capacity_cfg > CAP_CEILING) ? CAP_CEILING : int'(capacity_cfg);
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void push_result(logic kind, logic [7:0] vb, status_t st, logic [7:0] vl);
    form_result_t r;
    r.kind = kind;
    r.vbyte = vb;
    r.st = st;
    r.vlen = vl;
    r.last = kind;
    pending_results.push_back(r);
  endfunction

  function automatic void emit_decoded(logic [7:0] b);
    // one slot is kept back for the terminator of the output buffer
    if (value_count + 1 >= cap_limit()) begin
      body_status = ST_BAD;
      parse_phase = PH_DONE;
    end else begin
      push_result(1'b0, b, ST_FOUND, 8'd0);
      value_count++;
      parse_phase = PH_VALUE;
    end
  endfunction

  function automatic void absorb_body_item(logic [7:0] c, logic has, logic last);
    int h;
    status_t st;
    if (has) begin
      case (parse_phase)
        PH_KEY: begin
          if (c == CH_AMP) begin
            key_pos = 5'd0;
            key_miss = 1'b0;
          end else if (c == CH_EQ) begin
            parse_phase = (!key_miss && key_pos == key_len_cfg &&
                           key_len_cfg <= MAX_NAME_BYTES) ? PH_VALUE : PH_SKIP;
          end else if (key_miss || key_pos >= key_len_cfg || key_pos >= MAX_NAME_BYTES ||
                       name_cfg[int'(key_pos) * 8 +: 8] != c) begin
            key_miss = 1'b1;
          end else begin
            key_pos++;
          end
        end
        PH_SKIP: begin
          if (c == CH_AMP) begin
            parse_phase = PH_KEY;
            key_pos = 5'd0;
            key_miss = 1'b0;
          end
        end
        PH_VALUE: begin
          if (c == CH_AMP) begin
            body_status = ST_FOUND;
            parse_phase = PH_DONE;
          end else if (c == CH_PCT) begin
            parse_phase = PH_HEX1;
          end else begin
            emit_decoded((c == CH_PLUS) ? CH_SPACE : c);
          end
        end
        PH_HEX1: begin
          h = hex_value(c);
          if (h < 0) begin
            body_status = ST_BAD;
            parse_phase = PH_DONE;
          end else begin
            hi_nib = 4'(h);
            parse_phase = PH_HEX2;
          end
        end
        PH_HEX2: begin
          h = hex_value(c);
          if (h < 0) begin
            body_status = ST_BAD;
            parse_phase = PH_DONE;
          end else begin
            emit_decoded({hi_nib, 4'(h)});
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      case (parse_phase)
        PH_DONE: st = body_status;
        PH_VALUE: st = ST_FOUND;
        PH_HEX1, PH_HEX2: st = ST_BAD;
        default: st = ST_NOT_FOUND;
      endcase
      if (cap_limit() == 0) st = ST_BAD;
      push_result(1'b1, 8'd0, st, (st == ST_FOUND) ? 8'(value_count) : 8'd0);
      clear_parse_state();
    end
  endfunction

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    form_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0b data %0h last %0b",
                 $time, out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("item_kind", want.kind, out_tuser);
        compare_field("value_byte", want.vbyte, out_tdata[7:0]);
        compare_field("status", want.st, out_tdata[9:8]);
        compare_field("value_length", want.vlen, out_tdata[17:10]);
        compare_field("zero fill", 0, out_tdata[23:18]);
        compare_field("result_last", want.last, out_tlast);
      end
    end
  end

  // result side ready: random bursts of stall, or one long hold on request
  initial begin : result_sink
    wait (rst_n);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request <= 1'b0;
      end else if (idle_out && $urandom_range(5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(7, 1)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic has, input logic last);
    if (idle_in && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= has;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    absorb_body_item(b, has, last);
    if (has || last) bytes_taken++;
  endtask

  task automatic send_body();
    int k;
    bit tail_marker;
    tail_marker = body_buf.size() != 0 && $urandom_range(9) == 0;
    // an empty body is just the end marker
    if (body_buf.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
    for (k = 0; k < body_buf.size(); k++) begin
      if ($urandom_range(29) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(body_buf[k], 1'b1, (k == body_buf.size() - 1) && !tail_marker);
    end
    if (tail_marker) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NAME_LOW: name_cfg[63:0] = data;
      REG_NAME_HIGH: name_cfg[127:64] = data;
      REG_NAME_LEN: key_len_cfg = data[4:0];
      REG_CAPACITY: capacity_cfg = data[8:0];
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic set_config(input logic [127:0] nm, input logic [4:0] len,
                            input logic [8:0] cap);
    write_reg(REG_NAME_LOW, nm[63:0]);
    write_reg(REG_NAME_HIGH, nm[127:64]);
    write_reg(REG_NAME_LEN, {59'd0, len});
    write_reg(REG_CAPACITY, {55'd0, cap});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [127:0] letter_name(int len);
    logic [127:0] nm;
    int k;
    nm = {$urandom, $urandom, $urandom, $urandom};
    for (k = 0; k < len; k++) nm[8 * k +: 8] = 8'($urandom_range(8'h64, 8'h61));
    return nm;
  endfunction

  function automatic logic [7:0] hex_char(int n, bit upper);
    if (n < 10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n - 10);
  endfunction

  function automatic void load_text(string s);
    int k;
    body_buf.delete();
    for (k = 0; k < s.len(); k++) body_buf.push_back(s[k]);
  endfunction

  function automatic void add_key(int klen);
    int r, k, j, n;
    logic [7:0] b;
    r = $urandom_range(9);
    if (r <= 4 || (r == 5 && klen > 0)) begin
      j = (r == 5) ? $urandom_range(klen - 1) : -1;
      for (k = 0; k < klen; k++) begin
        b = name_cfg[8 * k +: 8];
        if (k == j) b = b ^ 8'($urandom_range(255, 1));
        body_buf.push_back(b);
      end
    end else if (r == 6) begin
      for (k = 0; k < klen - 1; k++) body_buf.push_back(name_cfg[8 * k +: 8]);
    end else if (r == 7) begin
      for (k = 0; k < klen; k++) body_buf.push_back(name_cfg[8 * k +: 8]);
      body_buf.push_back(8'($urandom_range(8'h64, 8'h61)));
    end else if (r <= 8) begin
      n = $urandom_range(4, 1);
      for (k = 0; k < n; k++) body_buf.push_back(8'($urandom_range(8'h64, 8'h61)));
    end
    // otherwise the key stays empty
  endfunction

  function automatic void add_value(int len);
    int k, r;
    for (k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        body_buf.push_back(8'($urandom_range(8'h7e, 8'h21)));
      end else if (r < 65) begin
        body_buf.push_back(CH_PLUS);
      end else if (r < 85) begin
        body_buf.push_back(CH_PCT);
        body_buf.push_back(hex_char($urandom_range(15), $urandom_range(1)));
        body_buf.push_back(hex_char($urandom_range(15), $urandom_range(1)));
      end else if (r < 95) begin
        body_buf.push_back(8'($urandom));
      end else begin
        // escape with arbitrary digits, mostly broken
        body_buf.push_back(CH_PCT);
        body_buf.push_back(8'($urandom));
        body_buf.push_back(8'($urandom));
      end
    end
  endfunction

  function automatic void make_body();
    int r, n, k, klen;
    body_buf.delete();
    r = $urandom_range(99);
    if (r < 4) return;
    if (r < 14) begin
      n = $urandom_range(16, 1);
      for (k = 0; k < n; k++) body_buf.push_back(8'($urandom));
      return;
    end
    klen = (key_len_cfg > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(key_len_cfg);
    n = $urandom_range(4, 1);
    for (k = 0; k < n; k++) begin
      if (k > 0) body_buf.push_back(CH_AMP);
      add_key(klen);
      if ($urandom_range(11) != 0) begin
        body_buf.push_back(CH_EQ);
        add_value($urandom_range(10));
      end
    end
    r = $urandom_range(19);
    if (r == 0) begin
      body_buf.push_back(CH_PCT);
    end else if (r == 1) begin
      body_buf.push_back(CH_PCT);
      body_buf.push_back(hex_char($urandom_range(15), $urandom_range(1)));
    end else if (r == 2) begin
      body_buf.push_back(CH_AMP);
    end
  endfunction

  task automatic test_basic_decode();
    set_config({$urandom, $urandom, $urandom, 24'($urandom), 8'h6b}, 5'd1, 9'd64);
    load_text("k=+%4a%FFx");
    send_body();
    wait_results_done();
  endtask

  task automatic test_no_match_and_idle();
    send_item(8'($urandom), 1'b0, 1'b1);
    // pair without '=', idle request inside, body closed by a byteless marker
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(CH_AMP, 1'b1, 1'b0);
    send_item(8'h6b, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_results_done();
  endtask

  task automatic test_bad_escapes();
    load_text("k=%");
    send_body();
    load_text("k=%&");
    send_body();
    wait_results_done();
  endtask

  task automatic test_capacity_edges();
    set_config(name_cfg, 5'd1, 9'd0);
    send_item(8'($urandom), 1'b0, 1'b1);
    wait_results_done();
    set_config(name_cfg, 5'd1, 9'd2);
    load_text("k=ab");
    send_body();
    wait_results_done();
  endtask

  task automatic test_long_values();
    int n, k;
    set_config(letter_name(1), 5'd1, 9'd256);
    // longest value that fits, then one byte more
    for (n = 255; n <= 256; n++) begin
      body_buf.delete();
      body_buf.push_back(name_cfg[7:0]);
      body_buf.push_back(CH_EQ);
      for (k = 0; k < n; k++) body_buf.push_back(8'($urandom_range(8'h5a, 8'h41)));
      send_body();
    end
    wait_results_done();
  endtask

  task automatic test_output_hold();
    int k;
    set_config(letter_name(2), 5'd2, 9'd64);
    idle_in = 1'b0;
    hold_request <= 1'b1;
    body_buf.delete();
    body_buf.push_back(name_cfg[7:0]);
    body_buf.push_back(name_cfg[15:8]);
    body_buf.push_back(CH_EQ);
    for (k = 0; k < 40; k++) body_buf.push_back(8'($urandom_range(8'h39, 8'h30)));
    send_body();
    wait_results_done();
    idle_in = 1'b1;
  endtask

  task automatic test_random_bodies();
    int phase_no, phase_start, random_start;
    random_start = bytes_taken;
    for (phase_no = 0; bytes_taken - random_start < RANDOM_ITEMS; phase_no++) begin
      case (phase_no)
        0: set_config(letter_name(2), 5'd2, 9'd64);
        1: set_config(letter_name(16), 5'd16, 9'd256);
        2: set_config(letter_name(4), 5'd0, 9'd5);
        3: set_config(letter_name(1), 5'd1, 9'd1);
        4: set_config(letter_name(3), 5'd3, 9'd0);
        5: set_config(letter_name(16), 5'($urandom_range(31, 17)), 9'd511);
        6: set_config({$urandom, $urandom, $urandom, $urandom}, 5'($urandom_range(16)),
                      9'($urandom_range(511)));
        7: set_config(letter_name(9), 5'd9, 9'd300);
        default: set_config(letter_name(8), 5'($urandom_range(8, 1)),
                            9'($urandom_range(40, 2)));
      endcase
      if (bytes_taken - random_start >= RANDOM_ITEMS - CALM_ITEMS) begin
        idle_in = 1'b0;
        idle_out = 1'b0;
      end else begin
        idle_in = $urandom_range(3) != 0;
        idle_out = $urandom_range(3) != 0;
      end
      phase_start = bytes_taken;
      while (bytes_taken - phase_start < PHASE_ITEMS &&
             bytes_taken - random_start < RANDOM_ITEMS) begin
        make_body();
        send_body();
      end
      wait_results_done();
    end
  endtask

  initial begin : run
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    clear_parse_state();
    test_basic_decode();
    test_no_match_and_idle();
    test_bad_escapes();
    test_capacity_edges();
    test_long_values();
    test_output_hold();
    test_random_bodies();
    wait_results_done();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
